>>> rtl/core/rde_pkg.sv
// shared types, constants and helpers of the reversible deque engine
`default_nettype none

package rde_pkg;

    localparam int DEQ_DEPTH  = 64;
    localparam int VALUE_BITS = 32;
    localparam int ITEM_BITS  = 32;
    localparam int STORE_W    = (VALUE_BITS < ITEM_BITS) ? VALUE_BITS : ITEM_BITS;

    localparam int AW = $clog2(DEQ_DEPTH);
    localparam int AP = AW + 1;
    localparam int CW = $clog2(DEQ_DEPTH + 1);

    localparam int FQ_DEPTH = 2;
    localparam int FQ_CW    = 2;

    localparam int OUTQ_DEPTH = 4;
    localparam int OQ_AW      = 2;
    localparam int OQ_CW      = 3;
    localparam int OQ_PW      = OQ_CW + 1;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_REVERSE = 2'd1,
        CMD_DELETE  = 2'd2,
        CMD_FINISH  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                        command;
        logic signed [ITEM_BITS-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [ITEM_BITS-1:0] element;
        logic                        failed;
        logic                        none_left;
        logic                        last;
    } result_t;

    typedef struct packed {
        cmd_t               kind;
        logic [STORE_W-1:0] value;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } op_chan_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } res_chan_t;

    typedef enum logic {
        BK_EXEC,
        BK_DRAIN
    } back_state_t;

    // sum of two in-range indexes is below twice the depth
    function automatic logic [AW-1:0] wrap_addr(input logic [AP-1:0] sum);
        if (sum >= AP'(DEQ_DEPTH))
            return AW'(sum - AP'(DEQ_DEPTH));
        else
            return sum[AW-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rde_ram.sv
// generic single write port ram with registered read
`default_nettype none

module rde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/rde_front.sv
// front end: takes commands, decodes them and queues them for the back end
`default_nettype none

module rde_front
    import rde_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output      logic     full,
    input  wire item_t    item,
    input  wire logic     take,
    output      op_chan_t op_out
);

    op_t              slot0_reg, slot0_next;
    op_t              slot1_reg, slot1_next;
    logic [FQ_CW-1:0] count_reg, count_next;
    op_t              new_op;
    logic             accept;

    assign full   = (count_reg == FQ_CW'(FQ_DEPTH));
    assign accept = push && !full;

    // value is kept in its low store bits only
    always_comb
    begin
        new_op.kind  = item.command;
        new_op.value = item.value[STORE_W-1:0];
    end

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        case ({accept, take})
            2'b11:
            begin
                if (count_reg == FQ_CW'(1))
                begin
                    slot0_next = new_op;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = new_op;
                end
            end
            2'b10:
            begin
                if (count_reg == '0)
                    slot0_next = new_op;
                else
                    slot1_next = new_op;
                count_next = count_reg + FQ_CW'(1);
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - FQ_CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign op_out.valid = (count_reg != '0);
    assign op_out.op    = slot0_reg;

endmodule

`default_nettype wire

>>> rtl/core/rde_back.sv
// back end: executes queued commands on the element store and drains it on finish
`default_nettype none

module rde_back
    import rde_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire op_chan_t         op_in,
    output      logic             take,
    input  wire logic [OQ_CW-1:0] oq_level,
    output      res_chan_t        res_out
);

    back_state_t      state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             rev_reg, rev_next;
    logic             err_reg, err_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             rd_last_reg, rd_last_next;

    logic               we;
    logic [AW-1:0]      waddr;
    logic               re;
    logic [AW-1:0]      raddr;
    logic [STORE_W-1:0] rdata;

    logic [OQ_PW-1:0] pending;
    logic             room;
    logic [CW-1:0]    pos;
    logic [CW-1:0]    idx_plus;
    logic             drain_last;
    logic             direct_push;
    result_t          direct_data;

    rde_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEQ_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (op_in.op.value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // a slot must be free for the read still in flight and the new one
    assign pending    = {1'b0, oq_level} + OQ_PW'(rd_valid_reg);
    assign room       = (pending < OQ_PW'(OUTQ_DEPTH - 1)) ||
                        (pending == OQ_PW'(OUTQ_DEPTH - 1));
    assign idx_plus   = CW'(idx_reg) + CW'(1);
    assign drain_last = (idx_plus == fill_reg);
    assign pos        = rev_reg ? (fill_reg - idx_plus) : CW'(idx_reg);
    assign raddr      = wrap_addr(AP'(head_reg) + AP'(pos));
    assign waddr      = wrap_addr(AP'(head_reg) + AP'(fill_reg));

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        rev_next      = rev_reg;
        err_next      = err_reg;
        idx_next      = idx_reg;
        rd_valid_next = 1'b0;
        rd_last_next  = rd_last_reg;
        take          = 1'b0;
        we            = 1'b0;
        re            = 1'b0;
        direct_push   = 1'b0;
        direct_data   = '0;
        case (state_reg)
            BK_EXEC:
            begin
                if (op_in.valid)
                begin
                    case (op_in.op.kind)
                        CMD_LOAD:
                        begin
                            take = 1'b1;
                            if (fill_reg >= CW'(DEQ_DEPTH))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                we        = 1'b1;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        CMD_REVERSE:
                        begin
                            take     = 1'b1;
                            rev_next = !rev_reg;
                        end
                        CMD_DELETE:
                        begin
                            take = 1'b1;
                            if (fill_reg == '0)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                if (!rev_reg)
                                    head_next = wrap_addr(AP'(head_reg) + AP'(1));
                                fill_next = fill_reg - CW'(1);
                            end
                        end
                        CMD_FINISH:
                        begin
                            if (err_reg || (fill_reg == '0))
                            begin
                                // single result shares the queue port with drain data
                                if (room && !rd_valid_reg)
                                begin
                                    take                  = 1'b1;
                                    direct_push           = 1'b1;
                                    direct_data.failed    = err_reg;
                                    direct_data.none_left = !err_reg;
                                    direct_data.last      = 1'b1;
                                    head_next             = '0;
                                    fill_next             = '0;
                                    rev_next              = 1'b0;
                                    err_next              = 1'b0;
                                end
                            end
                            else
                            begin
                                take       = 1'b1;
                                idx_next   = '0;
                                state_next = BK_DRAIN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_DRAIN:
            begin
                if (room)
                begin
                    re            = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_last_next  = drain_last;
                    idx_next      = idx_plus[AW-1:0];
                    if (drain_last)
                    begin
                        head_next  = '0;
                        fill_next  = '0;
                        rev_next   = 1'b0;
                        err_next   = 1'b0;
                        state_next = BK_EXEC;
                    end
                end
            end
            default:
            begin
                state_next = BK_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_EXEC;
            head_reg     <= '0;
            fill_reg     <= '0;
            rev_reg      <= 1'b0;
            err_reg      <= 1'b0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            rev_reg      <= rev_next;
            err_reg      <= err_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_valid_next;
            rd_last_reg  <= rd_last_next;
        end
    end

    always_comb
    begin
        res_out.valid = rd_valid_reg || direct_push;
        if (rd_valid_reg)
        begin
            res_out.data.element   = ITEM_BITS'(rdata);
            res_out.data.failed    = 1'b0;
            res_out.data.none_left = 1'b0;
            res_out.data.last      = rd_last_reg;
        end
        else
        begin
            res_out.data = direct_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rde_out_queue.sv
// result queue between the back end and the result ports
`default_nettype none

module rde_out_queue
    import rde_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire res_chan_t        res_in,
    input  wire logic             pop,
    output      logic             empty,
    output      result_t          head,
    output      logic [OQ_CW-1:0] level
);

    result_t          entry_reg [OUTQ_DEPTH];
    logic [OQ_AW-1:0] wptr_reg, wptr_next;
    logic [OQ_AW-1:0] rptr_reg, rptr_next;
    logic [OQ_CW-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign do_pop  = pop && !empty;
    assign do_push = res_in.valid && (count_reg != OQ_CW'(OUTQ_DEPTH));

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + OQ_AW'(1) : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + OQ_AW'(1) : rptr_reg;
        count_next = count_reg + OQ_CW'(do_push) - OQ_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= res_in.data;
        end
    end

    assign head  = entry_reg[rptr_reg];
    assign level = count_reg;

endmodule

`default_nettype wire

>>> rtl/core/reversible_deque_engine.sv
// top level of the reversible deque engine
`default_nettype none

// Reversible deque engine. Commands enter through a two-entry command queue
// (push/full) and results leave through a four-entry result queue
// (empty/pop). Load, reverse and delete are each taken by the back end
// without waiting, so a stream of them is taken at one per cycle. A finish
// that reports an error or an empty buffer pushes its single result in the
// same cycle that it is taken, but waits while the last read of a drain is
// still in flight or the result queue lacks room. A finish with n elements
// left first starts the drain and then reads the elements out of the element
// store one per cycle, paced by the single read port of the store and by free
// room in the result queue. Commands behind a finish wait in the command
// queue until the drain has been issued. A single report reaches the result
// ports through the result queue entry register, and the first drained
// element through the drain state, the read register of the store and the
// result queue. No clearing pass is needed after reset.
module reversible_deque_engine
    import rde_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    output      logic    full,
    input  wire item_t   item,
    output      logic    empty,
    input  wire logic    pop,
    output      result_t result
);

    op_chan_t         op_chan;
    logic             take;
    res_chan_t        res_chan;
    logic [OQ_CW-1:0] oq_level;

    rde_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .take   (take),
        .op_out (op_chan)
    );

    rde_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_in    (op_chan),
        .take     (take),
        .oq_level (oq_level),
        .res_out  (res_chan)
    );

    rde_out_queue u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .res_in (res_chan),
        .pop    (pop),
        .empty  (empty),
        .head   (result),
        .level  (oq_level)
    );

endmodule

`default_nettype wire

>>> rtl/core/rde_checker.sv
// port level checks of the reversible deque engine and their bind
`default_nettype none

module rde_checker
    import rde_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    push,
    input wire logic    full,
    input wire item_t   item,
    input wire logic    empty,
    input wire logic    pop,
    input wire result_t result
);

    // error and empty reports are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.failed && result.none_left))
        else $error("result marked both failed and none_left");

    // a single report closes its case and carries no element
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.failed || result.none_left)) |->
            (result.last && (result.element == '0)))
        else $error("single report not last or element not zero");

    // a waiting result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

    // nothing to deliver right after reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result queue not empty after reset");

endmodule

bind reversible_deque_engine rde_checker u_rde_checker (.*);

`default_nettype wire

>>> verif/reversible_deque_engine_tb.sv
// self-checking testbench of the reversible deque engine
`timescale 1ns / 100ps

module reversible_deque_engine_tb;
    import rde_pkg::*;

    localparam int ITEM_TARGET = 370;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 24;

    typedef enum int {
        CASE_SHORT,
        CASE_FULL,
        CASE_NOISE
    } case_kind_t;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } step_row_t;

    localparam result_t NOTHING_LEFT = {32'sd0, 1'b0, 1'b1, 1'b1};
    localparam result_t CASE_FAILED  = {32'sd0, 1'b1, 1'b0, 1'b1};

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    item_t   item  = '0;
    logic    full;
    logic    empty;
    result_t result;

    // predictor state
    logic [STORE_W-1:0] ring [DEQ_DEPTH];
    logic [AW-1:0]      ring_head;
    logic [CW-1:0]      ring_fill;
    bit                 ring_rev;
    bit                 ring_err;

    result_t   step_out[$];
    result_t   drain_expect[$];
    step_row_t plan[$];
    item_t     case_q[$];

    bit calm;
    int items_sent;
    int cases_sent;
    int overflow_cases;
    int results_checked;
    int failed_seen;
    int empty_seen;
    int mismatches;
    int unsigned quiet;

    reversible_deque_engine i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // advances the predicted deque by one command, results go to step_out
    task automatic deque_step(input item_t it);
        result_t r;
        int      pos;
        step_out = {};
        case (it.command)
            CMD_LOAD:
            begin
                if (ring_fill >= DEQ_DEPTH)
                    ring_err = 1'b1;
                else
                begin
                    ring[(int'(ring_head) + int'(ring_fill)) % DEQ_DEPTH] =
                        it.value[STORE_W-1:0];
                    ring_fill++;
                end
            end
            CMD_REVERSE:
                ring_rev = !ring_rev;
            CMD_DELETE:
            begin
                if (ring_fill == 0)
                    ring_err = 1'b1;
                else
                begin
                    // reversed front is the physical back, head stays
                    if (!ring_rev)
                        ring_head = AW'((int'(ring_head) + 1) % DEQ_DEPTH);
                    ring_fill--;
                end
            end
            default:
            begin
                if (ring_err)
                    step_out = {step_out, CASE_FAILED};
                else if (ring_fill == 0)
                    step_out = {step_out, NOTHING_LEFT};
                else
                begin
                    for (int i = 0; i < int'(ring_fill); i++)
                    begin
                        pos         = ring_rev ? (int'(ring_fill) - 1 - i) : i;
                        r.element   = ring[(int'(ring_head) + pos) % DEQ_DEPTH];
                        r.failed    = 1'b0;
                        r.none_left = 1'b0;
                        r.last      = (i == int'(ring_fill) - 1);
                        step_out    = {step_out, r};
                    end
                end
                ring_head = '0;
                ring_fill = '0;
                ring_rev  = 1'b0;
                ring_err  = 1'b0;
            end
        endcase
    endtask

    task automatic add_row(input cmd_t c, input logic [31:0] v, input bit typed,
                           input result_t want);
        step_row_t row;
        row.it.command = c;
        row.it.value   = v;
        row.typed      = typed;
        row.want       = want;
        plan = {plan, row};
    endtask

    // one command transfer, then the predictor sees it
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        deque_step(it);
        if (typed)
            drain_expect = {drain_expect, want};
        else
            foreach (step_out[k])
                drain_expect = {drain_expect, step_out[k]};
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t make_item(input cmd_t c);
        item_t it;
        it.command = c;
        it.value   = (c == CMD_LOAD) ? pick_value() : $urandom;
        return it;
    endfunction

    // builds one case ending in a finish; every case starts from a cleared deque
    task automatic build_case(input case_kind_t kind);
        int n;
        int k;
        int held;
        int r;
        case_q = {};
        held   = 0;
        case (kind)
            CASE_FULL:
            begin
                for (int i = 0; i < DEQ_DEPTH; i++)
                    case_q = {case_q, make_item(CMD_LOAD)};
                if ($urandom_range(0, 1))
                begin
                    // overflow: dropped loads, sticky error
                    overflow_cases++;
                    n = $urandom_range(1, 2);
                    for (int i = 0; i < n; i++)
                        case_q = {case_q, make_item(CMD_LOAD)};
                end
                else
                begin
                    // front deletes then refill so the ring wraps
                    k = $urandom_range(1, 8);
                    for (int i = 0; i < k; i++)
                        case_q = {case_q, make_item(CMD_DELETE)};
                    for (int i = 0; i < k; i++)
                        case_q = {case_q, make_item(CMD_LOAD)};
                    if ($urandom_range(0, 1))
                        case_q = {case_q, make_item(CMD_REVERSE)};
                end
            end
            CASE_NOISE:
            begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    case_q = {case_q, make_item(cmd_t'($urandom_range(0, 3)))};
            end
            default:
            begin
                n = $urandom_range(1, 16);
                for (int i = 0; i < n; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 55)
                    begin
                        case_q = {case_q, make_item(CMD_LOAD)};
                        held++;
                    end
                    else if (r < 70)
                        case_q = {case_q, make_item(CMD_REVERSE)};
                    else if (held > 0 || $urandom_range(0, 9) == 0)
                    begin
                        case_q = {case_q, make_item(CMD_DELETE)};
                        if (held > 0)
                            held--;
                    end
                    else
                    begin
                        case_q = {case_q, make_item(CMD_LOAD)};
                        held++;
                    end
                end
            end
        endcase
        case_q = {case_q, make_item(CMD_FINISH)};
    endtask

    // no transfer on either side for too long means the block hung
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet <= 0;
        else if ((push && !full) || (pop && !empty))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("timeout after %0d cycles without a transfer", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // result side: random pop stalls, each transfer checked against the oldest expectation
    initial
    begin
        int      gap;
        result_t want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            results_checked++;
            if (result.failed)
                failed_seen++;
            if (result.none_left)
                empty_seen++;
            if (drain_expect.size() == 0)
                report_mismatch($sformatf("unexpected result element=%0d f=%0b n=%0b l=%0b",
                    result.element, result.failed, result.none_left, result.last));
            else
            begin
                want = drain_expect[0];
                drain_expect.delete(0);
                if (result.element !== want.element)
                    report_mismatch($sformatf("element %0d, expected %0d",
                        result.element, want.element));
                if (result.failed !== want.failed)
                    report_mismatch($sformatf("failed %0b, expected %0b",
                        result.failed, want.failed));
                if (result.none_left !== want.none_left)
                    report_mismatch($sformatf("none_left %0b, expected %0b",
                        result.none_left, want.none_left));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                        result.last, want.last));
            end
        end
    end

    initial
    begin
        ring_head = '0;
        ring_fill = '0;
        ring_rev  = 1'b0;
        ring_err  = 1'b0;
        calm      = 1'b0;

        add_row(CMD_FINISH,  32'h0,         1, NOTHING_LEFT);
        add_row(CMD_DELETE,  32'h0,         0, '0);
        add_row(CMD_FINISH,  32'h0,         1, CASE_FAILED);
        add_row(CMD_LOAD,    32'h7fff_ffff, 0, '0);
        add_row(CMD_LOAD,    32'h8000_0000, 0, '0);
        add_row(CMD_LOAD,    32'hffff_ffff, 0, '0);
        add_row(CMD_LOAD,    32'h0000_0000, 0, '0);
        add_row(CMD_FINISH,  32'h0,         0, '0);
        add_row(CMD_LOAD,    32'h1,         0, '0);
        add_row(CMD_LOAD,    32'h2,         0, '0);
        add_row(CMD_LOAD,    32'h3,         0, '0);
        add_row(CMD_REVERSE, 32'h0,         0, '0);
        add_row(CMD_DELETE,  32'h0,         0, '0);
        add_row(CMD_FINISH,  32'h0,         0, '0);
        add_row(CMD_LOAD,    32'ha5a5_a5a5, 0, '0);
        add_row(CMD_REVERSE, 32'h0,         0, '0);
        add_row(CMD_DELETE,  32'h0,         0, '0);
        // delete on empty, later commands still act but the finish only fails
        add_row(CMD_DELETE,  32'h0,         0, '0);
        add_row(CMD_LOAD,    32'h5a5a_5a5a, 0, '0);
        add_row(CMD_REVERSE, 32'hdead_beef, 0, '0);
        add_row(CMD_FINISH,  32'h0,         1, CASE_FAILED);
        add_row(CMD_LOAD,    32'h5555_5555, 0, '0);
        add_row(CMD_DELETE,  32'h0,         0, '0);
        add_row(CMD_FINISH,  32'h0,         1, NOTHING_LEFT);
        add_row(CMD_REVERSE, 32'h0,         0, '0);
        add_row(CMD_FINISH,  32'h0,         1, NOTHING_LEFT);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].it, plan[i].typed, plan[i].want);

        // first random case always fills the deque
        while (items_sent < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if (cases_sent == 0 || $urandom_range(0, 14) == 0)
                build_case(CASE_FULL);
            else if ($urandom_range(0, 9) == 0)
                build_case(CASE_NOISE);
            else
                build_case(CASE_SHORT);
            foreach (case_q[i])
                send_item(case_q[i], 1'b0, '0);
            cases_sent++;
        end
        push <= 1'b0;
        calm = 1'b0;

        while (drain_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (drain_expect.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", drain_expect.size()));
        $display("covered %0d commands in %0d random cases (%0d with overflow)",
            items_sent, cases_sent, overflow_cases);
        $display("checked %0d results: %0d error, %0d empty, %0d mismatches",
            results_checked, failed_seen, empty_seen, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> reversible_deque_engine.f
rtl/core/rde_pkg.sv
rtl/core/rde_ram.sv
rtl/core/rde_front.sv
rtl/core/rde_back.sv
rtl/core/rde_out_queue.sv
rtl/core/reversible_deque_engine.sv
rtl/core/rde_checker.sv
verif/reversible_deque_engine_tb.sv
